FILE: design/fls_pkg.sv
// Shared types, codes and field widths for the free-list slot allocator.
package fls_pkg;

	localparam int ACT_W = 2;
	localparam int IDX_W = 8;
	localparam int VAL_W = 32;
	localparam int CNT_W = 9;
	localparam int ST_W  = 2;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [ST_W-1:0] ST_INACTIVE = 2'd3;

	// One slot as held in the slot memory.
	typedef struct packed {
		logic             active;
		logic             link_valid;
		logic [VAL_W-1:0] value;
	} fls_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} fls_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
	} fls_sts_t;

endpackage

FILE: design/fls_req_if.sv
// Request channel of the slot allocator: action, slot index and write value.
interface fls_req_if;
	logic                               valid;
	logic                               ready;
	logic [fls_pkg::ACT_W-1:0]          action;
	logic [fls_pkg::IDX_W-1:0]          slot_index;
	logic signed [fls_pkg::VAL_W-1:0]   write_value;

	modport source (output valid, output action, output slot_index, output write_value,
		input ready);
	modport sink (input valid, input action, input slot_index, input write_value,
		output ready);
endinterface

FILE: design/fls_rsp_if.sv
// Result channel of the slot allocator: granted slot, read value, count and status.
interface fls_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [fls_pkg::IDX_W-1:0]          granted_slot;
	logic signed [fls_pkg::VAL_W-1:0]   read_value;
	logic [fls_pkg::CNT_W-1:0]          used_count;
	logic [fls_pkg::ST_W-1:0]           status;

	modport source (output valid, output granted_slot, output read_value,
		output used_count, output status, input ready);
	modport sink (input valid, input granted_slot, input read_value,
		input used_count, input status, output ready);
endinterface

FILE: design/fls_ctrl.sv
// Controller state machine: clearing pass, request acceptance and result handover.
module fls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fls_pkg::fls_sts_t sts,
	output fls_pkg::fls_cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       load;
	logic       exec_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign load      = in_valid && in_ready;
	// The result may only be committed once the output register is free or being emptied.
	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	assign cmd.clear = (state_q == S_CLEAR);
	assign cmd.load  = load;
	assign cmd.exec  = exec_fire;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (load)
					state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (exec_fire)
					state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (exec_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: design/fls_dp.sv
// Datapath: slot and link memories, free-list head, allocated count and result register.
module fls_dp #(
	parameter int SLOTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fls_pkg::fls_cmd_t                cmd,
	output fls_pkg::fls_sts_t                sts,
	input  logic [fls_pkg::ACT_W-1:0]        action,
	input  logic [fls_pkg::IDX_W-1:0]        slot_index,
	input  logic signed [fls_pkg::VAL_W-1:0] write_value,
	output logic [fls_pkg::IDX_W-1:0]        granted_slot,
	output logic signed [fls_pkg::VAL_W-1:0] read_value,
	output logic [fls_pkg::CNT_W-1:0]        used_count,
	output logic [fls_pkg::ST_W-1:0]         status
);

	localparam int AW = $clog2(SLOTS);
	localparam int HW = AW + 1;
	localparam int CW = $clog2(SLOTS + 1);

	fls_pkg::fls_word_t slot_mem [SLOTS];
	logic [HW-1:0]      link_mem [SLOTS];

	logic [fls_pkg::ACT_W-1:0] act_q;
	logic [fls_pkg::IDX_W-1:0] idx_q;
	logic [fls_pkg::VAL_W-1:0] wval_q;
	logic [AW-1:0]             addr_q;
	fls_pkg::fls_word_t        rd_word_q;
	logic [HW-1:0]             rd_link_q;
	logic [HW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             clr_addr_q;

	logic [AW-1:0]             rd_addr;
	logic                      full;
	logic                      in_range;
	logic                      wr_en;
	fls_pkg::fls_word_t        wr_word;
	logic                      link_we;
	logic [HW-1:0]             head_nxt;
	logic [CW-1:0]             count_nxt;
	logic [fls_pkg::IDX_W-1:0] grant_nxt;
	logic [fls_pkg::VAL_W-1:0] rval_nxt;
	logic [fls_pkg::ST_W-1:0]  status_nxt;

	// An allocate looks up the head slot; every other action looks up the addressed slot.
	assign rd_addr = (action == fls_pkg::ACT_ALLOC) ? head_q[AW-1:0] : AW'(slot_index);

	assign full     = (32'(count_q) >= 32'(SLOTS)) || (32'(head_q) >= 32'(SLOTS));
	assign in_range = 32'(idx_q) < 32'(SLOTS);
	assign sts.clr_last = (clr_addr_q == AW'(SLOTS - 1));

	always_comb begin
		wr_en      = 1'b0;
		wr_word    = rd_word_q;
		link_we    = 1'b0;
		head_nxt   = head_q;
		count_nxt  = count_q;
		grant_nxt  = '0;
		rval_nxt   = '0;
		status_nxt = fls_pkg::ST_OK;
		if (act_q == fls_pkg::ACT_ALLOC) begin
			if (full) begin
				status_nxt = fls_pkg::ST_FULL;
			end else begin
				wr_en          = 1'b1;
				wr_word.active = 1'b1;
				// A slot never freed has no link and falls through to its successor.
				head_nxt  = rd_word_q.link_valid ? rd_link_q : head_q + HW'(1);
				count_nxt = count_q + CW'(1);
				grant_nxt = fls_pkg::IDX_W'(addr_q);
			end
		end else if (!in_range) begin
			status_nxt = fls_pkg::ST_RANGE;
		end else begin
			case (act_q)
				fls_pkg::ACT_FREE: begin
					if (!rd_word_q.active) begin
						status_nxt = fls_pkg::ST_INACTIVE;
					end else begin
						wr_en              = 1'b1;
						wr_word.active     = 1'b0;
						wr_word.link_valid = 1'b1;
						wr_word.value      = '0;
						link_we            = 1'b1;
						head_nxt           = HW'(addr_q);
						count_nxt          = count_q - CW'(1);
					end
				end
				fls_pkg::ACT_READ: begin
					rval_nxt = rd_word_q.value;
				end
				fls_pkg::ACT_WRITE: begin
					wr_en         = 1'b1;
					wr_word.value = wval_q;
				end
				default: begin
					status_nxt = fls_pkg::ST_OK;
				end
			endcase
		end
	end

	// Slot memory: one write port shared by the clearing pass and the commit step.
	always_ff @(posedge clk) begin
		if (cmd.clear)
			slot_mem[clr_addr_q] <= '0;
		else if (cmd.exec && wr_en)
			slot_mem[addr_q] <= wr_word;
		if (cmd.load)
			rd_word_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && link_we)
			link_mem[addr_q] <= head_q;
		if (cmd.load)
			rd_link_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			idx_q  <= slot_index;
			wval_q <= write_value;
			addr_q <= rd_addr;
		end
		if (cmd.exec) begin
			granted_slot <= grant_nxt;
			read_value   <= rval_nxt;
			used_count   <= fls_pkg::CNT_W'(count_nxt);
			status       <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clear)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.exec) begin
				head_q  <= head_nxt;
				count_q <= count_nxt;
			end
		end
	end

endmodule

FILE: design/free_list_slot_allocator_unit.sv
// Free-list slot allocator: a pool of SLOTS 32-bit slots with an in-slot free list.
//
// Requests arrive on req (action, slot_index, write_value) with a valid/ready
// handshake; each request yields exactly one result on rsp (granted_slot,
// read_value, used_count, status), in request order.
// At the accepting edge the addressed slot (or the free-list head for an
// allocate) is read from the slot and link memories into registers; a later
// edge, once the result register is free or being emptied, commits the update
// and loads the result register. Only one request is in work at a time: a
// new request is accepted only after the previous one has committed.
// The result register parts the two channels: a request is still accepted
// while a result waits; while the receiver stalls with the register full, the
// commit step holds and no further request is accepted.
// After reset a clearing pass zeroes the slot memory, one slot per cycle;
// ready stays low until it ends. The count and head reset at once.
module free_list_slot_allocator_unit #(
	parameter int SLOTS = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	fls_req_if.sink  req,
	fls_rsp_if.source rsp
);

	fls_pkg::fls_cmd_t cmd;
	fls_pkg::fls_sts_t sts;

	fls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fls_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (req.action),
		.slot_index   (req.slot_index),
		.write_value  (req.write_value),
		.granted_slot (rsp.granted_slot),
		.read_value   (rsp.read_value),
		.used_count   (rsp.used_count),
		.status       (rsp.status)
	);

endmodule

FILE: design/fls_checker.sv
// Port-level checks for the slot allocator, bound to its top level.
module fls_checker #(
	parameter int SLOTS = 256
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [fls_pkg::IDX_W-1:0]        granted_slot,
	input logic signed [fls_pkg::VAL_W-1:0] read_value,
	input logic [fls_pkg::CNT_W-1:0]        used_count,
	input logic [fls_pkg::ST_W-1:0]         status
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in work");

	// A fresh result is preceded by a matching accepted request.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching request");

	// Refused requests hand out nothing, and the count never exceeds the pool.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(used_count) <= 32'(SLOTS)) &&
			((status == fls_pkg::ST_OK) || (granted_slot == '0 && read_value == '0)))
		else $error("refused request carries data or count out of range");

endmodule

bind free_list_slot_allocator_unit fls_checker #(
	.SLOTS (SLOTS)
) u_fls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.granted_slot (rsp.granted_slot),
	.read_value   (rsp.read_value),
	.used_count   (rsp.used_count),
	.status       (rsp.status)
);
